FILE: design/c39p_pkg.sv
// Shared types, constants and the symbol table for the Code 39 module packer.
`default_nettype none

package c39p_pkg;

    localparam int ELEMENT_COUNT = 9;
    localparam int BYTE_W        = 8;
    localparam int PATTERN_W     = 32;
    localparam int LEN_W         = 6;
    localparam int ACC_W         = PATTERN_W + BYTE_W - 1;
    localparam int CNT_W         = 6;
    localparam int OFF_W         = 7;
    localparam int WIDE_W        = 3;
    localparam int NARROW_W      = 2;
    localparam int CFG_DATA_W    = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDE_W-1:0]   WIDE_CAP     = 3'd6;
    localparam logic [NARROW_W-1:0] NARROW_CAP   = 2'd2;
    localparam logic [WIDE_W-1:0]   WIDE_RESET   = 3'd2;
    localparam logic [NARROW_W-1:0] NARROW_RESET = 2'd1;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_WIDE   = 1'b0;
    localparam cfg_index_t CFG_NARROW = 1'b1;

    typedef struct packed {
        logic [WIDE_W-1:0]   wide;
        logic [NARROW_W-1:0] narrow;
    } cfg_t;

    typedef struct packed {
        logic                     found;
        logic [ELEMENT_COUNT-1:0] mask;   // msb is the first element, 1 = wide
    } lookup_t;

    // One classified character, as queued between front and back.
    typedef struct packed {
        logic                 bad;
        logic                 eom;
        logic [PATTERN_W-1:0] pattern;  // first module in bit 0
        logic [LEN_W-1:0]     len;
    } entry_t;

    function automatic lookup_t c39p_lookup(input logic [7:0] ch);
        lookup_t r;
        r.found = 1'b1;
        case (ch)
            8'h30:   r.mask = 9'b000110100; // 0
            8'h31:   r.mask = 9'b100100001;
            8'h32:   r.mask = 9'b001100001;
            8'h33:   r.mask = 9'b101100000;
            8'h34:   r.mask = 9'b000110001;
            8'h35:   r.mask = 9'b100110000;
            8'h36:   r.mask = 9'b001110000;
            8'h37:   r.mask = 9'b000100101;
            8'h38:   r.mask = 9'b100100100;
            8'h39:   r.mask = 9'b001100100; // 9
            8'h41:   r.mask = 9'b100001001; // A
            8'h42:   r.mask = 9'b001001001;
            8'h43:   r.mask = 9'b101001000;
            8'h44:   r.mask = 9'b000011001;
            8'h45:   r.mask = 9'b100011000;
            8'h46:   r.mask = 9'b001011000;
            8'h47:   r.mask = 9'b000001101;
            8'h48:   r.mask = 9'b100001100;
            8'h49:   r.mask = 9'b001001100;
            8'h4A:   r.mask = 9'b000011100;
            8'h4B:   r.mask = 9'b100000011;
            8'h4C:   r.mask = 9'b001000011;
            8'h4D:   r.mask = 9'b101000010;
            8'h4E:   r.mask = 9'b000010011;
            8'h4F:   r.mask = 9'b100010010;
            8'h50:   r.mask = 9'b001010010;
            8'h51:   r.mask = 9'b000000111;
            8'h52:   r.mask = 9'b100000110;
            8'h53:   r.mask = 9'b001000110;
            8'h54:   r.mask = 9'b000010110;
            8'h55:   r.mask = 9'b110000001;
            8'h56:   r.mask = 9'b011000001;
            8'h57:   r.mask = 9'b111000000;
            8'h58:   r.mask = 9'b010010001;
            8'h59:   r.mask = 9'b110010000;
            8'h5A:   r.mask = 9'b011010000; // Z
            8'h2D:   r.mask = 9'b010000101; // -
            8'h2E:   r.mask = 9'b110000100; // .
            8'h20:   r.mask = 9'b011000100; // space
            8'h2A:   r.mask = 9'b010010100; // start/stop
            8'h24:   r.mask = 9'b010101000; // $
            8'h2F:   r.mask = 9'b010100010; // /
            8'h2B:   r.mask = 9'b010001010; // +
            8'h25:   r.mask = 9'b000101010; // %
            default: begin
                r.found = 1'b0;
                r.mask  = '0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/c39p_front.sv
// Front end: symbol lookup and expansion of one character into bar modules.
`default_nettype none

module c39p_front (
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [7:0]                 s_char_code,
    input  wire                        s_end_of_message,
    input  wire  c39p_pkg::cfg_t       cfg,
    output logic                       push_valid,
    input  wire                        push_ready,
    output c39p_pkg::entry_t           push_entry
);
    import c39p_pkg::*;

    lookup_t                 lk;
    logic [WIDE_W-1:0]       wide_eff;
    logic [NARROW_W-1:0]     narrow_eff;
    logic [3:0]              wide_before;
    logic [3:0]              narrow_before;
    logic [3:0]              wide_total;
    logic [OFF_W-1:0]        off;
    logic [OFF_W-1:0]        len_full;
    logic [WIDE_W-1:0]       el_w;
    logic [PATTERN_W-1:0]    pattern;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        lk         = c39p_lookup(s_char_code);
        wide_eff   = (cfg.wide > WIDE_CAP) ? WIDE_CAP : cfg.wide;
        narrow_eff = (cfg.narrow > NARROW_CAP) ? NARROW_CAP : cfg.narrow;

        // each bar is placed independently: its offset is the weighted count
        // of the wide and narrow elements ahead of it
        pattern       = '0;
        wide_before   = '0;
        narrow_before = '0;
        off           = '0;
        el_w          = '0;
        for (int e = 0; e < ELEMENT_COUNT; e++) begin
            wide_before   = 4'($countones(lk.mask & ~({ELEMENT_COUNT{1'b1}} >> e)));
            narrow_before = 4'(e) - wide_before;
            off  = OFF_W'(wide_before) * OFF_W'(wide_eff)
                 + OFF_W'(narrow_before) * OFF_W'(narrow_eff);
            el_w = lk.mask[ELEMENT_COUNT-1-e] ? wide_eff : WIDE_W'(narrow_eff);
            if ((e & 1) == 0) begin
                pattern = pattern | ((~({PATTERN_W{1'b1}} << el_w)) << off);
            end
        end

        // nine elements plus the narrow inter-character gap
        wide_total = 4'($countones(lk.mask));
        len_full   = OFF_W'(wide_total) * OFF_W'(wide_eff)
                   + OFF_W'(4'(ELEMENT_COUNT + 1) - wide_total) * OFF_W'(narrow_eff);

        push_entry.bad     = !lk.found;
        push_entry.eom     = s_end_of_message;
        push_entry.pattern = lk.found ? pattern : '0;
        push_entry.len     = lk.found ? len_full[LEN_W-1:0] : '0;
    end

endmodule

`default_nettype wire

FILE: design/c39p_queue.sv
// Small FIFO of classified characters between front and back ends.
`default_nettype none

module c39p_queue (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       push_valid,
    output logic                      push_ready,
    input  wire  c39p_pkg::entry_t    push_entry,
    output logic                      pop_valid,
    input  wire                       pop_ready,
    output c39p_pkg::entry_t          pop_entry
);
    import c39p_pkg::*;

    entry_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                     do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTH
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH))
        || ((wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_W-1:0]))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

FILE: design/c39p_back.sv
// Back end: merges module patterns with the carry and emits packed bytes.
`default_nettype none

module c39p_back (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       pop_valid,
    output logic                      pop_ready,
    input  wire  c39p_pkg::entry_t    pop_entry,
    output logic                      m_valid,
    input  wire                       m_ready,
    output logic [7:0]                m_pattern_byte,
    output logic                      m_last_of_run,
    output logic                      m_bad_char
);
    import c39p_pkg::*;

    // acc_reg/cnt_reg hold pending modules; between items they are the carry
    logic [ACC_W-1:0]   acc_reg, acc_next, acc_base;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_base, rem;
    logic               active_reg, active_next;
    logic               bad_reg, bad_next;
    logic               eom_reg, eom_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic               out_bad_reg, out_bad_next;
    logic               slot_free, emit, done, do_pop;

    assign m_valid        = out_valid_reg;
    assign m_pattern_byte = out_byte_reg;
    assign m_last_of_run  = out_last_reg;
    assign m_bad_char     = out_bad_reg;

    assign slot_free = !out_valid_reg || m_ready;
    assign rem       = cnt_reg - CNT_W'(BYTE_W);

    always_comb begin
        emit          = 1'b0;
        done          = !active_reg;
        acc_base      = acc_reg;
        cnt_base      = cnt_reg;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        out_bad_next  = out_bad_reg;
        if (active_reg) begin
            if (bad_reg) begin
                if (slot_free) begin
                    emit          = 1'b1;
                    out_byte_next = '0;
                    out_last_next = 1'b1;
                    out_bad_next  = 1'b1;
                    done          = 1'b1;
                end
            end else if (cnt_reg >= CNT_W'(BYTE_W)) begin
                if (slot_free) begin
                    emit          = 1'b1;
                    out_byte_next = acc_reg[BYTE_W-1:0];
                    out_last_next = !((rem >= CNT_W'(BYTE_W)) || (eom_reg && rem != '0));
                    out_bad_next  = 1'b0;
                    acc_base      = acc_reg >> BYTE_W;
                    cnt_base      = rem;
                    done          = out_last_next;
                end
            end else if (eom_reg && cnt_reg != '0) begin
                // flush: bits above the count are already zero
                if (slot_free) begin
                    emit          = 1'b1;
                    out_byte_next = acc_reg[BYTE_W-1:0];
                    out_last_next = 1'b1;
                    out_bad_next  = 1'b0;
                    acc_base      = '0;
                    cnt_base      = '0;
                    done          = 1'b1;
                end
            end else begin
                done = 1'b1;
            end
        end
    end

    assign pop_ready = done;
    assign do_pop    = done && pop_valid;

    always_comb begin
        active_next    = active_reg;
        bad_next       = bad_reg;
        eom_next       = eom_reg;
        acc_next       = acc_base;
        cnt_next       = cnt_base;
        out_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
        if (do_pop) begin
            active_next = 1'b1;
            bad_next    = pop_entry.bad;
            eom_next    = pop_entry.eom;
            if (!pop_entry.bad) begin
                acc_next = acc_base | (ACC_W'(pop_entry.pattern) << cnt_base[2:0]);
                cnt_next = cnt_base + CNT_W'(pop_entry.len);
            end
        end else if (done) begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bad_reg      <= bad_next;
        eom_reg      <= eom_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

`ifndef SYNTH
    a_carry_short: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (cnt_reg < CNT_W'(BYTE_W)))
        else $error("carry holds a full byte between characters");

    a_acc_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg >> cnt_reg) == '0)
        else $error("stale modules above the pending count");

    a_bad_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_char) |-> (m_last_of_run && m_pattern_byte == '0))
        else $error("bad character result is not a lone empty byte");
`endif

endmodule

`default_nettype wire

FILE: design/code39_bar_module_packer.sv
// Top level of the Code 39 bar module packer: config registers and pipeline.
//
//  Channel   Dir   Ports                                       Transfer
//  input     in    s_valid/s_ready, s_char_code, s_end_of_message  valid & ready
//  result    out   m_valid/m_ready, m_pattern_byte, m_last_of_run,  valid & ready
//                  m_bad_char
//  config    in    cfg_valid/cfg_ready, cfg_index, cfg_data     valid & ready
//
//  One input transaction produces its result count k (0..5) of bytes:
//  the back end emits one byte per cycle into its output register while
//  m_ready allows. The front end classifies in the accept cycle and writes
//  a 4-entry queue, so it keeps accepting while bytes drain.
//  Reset (aresetn low, synchronous) empties the queue, clears the carry and
//  loads wide_modules = 2, narrow_modules = 1. A stalled m_ready holds the
//  output register; the queue then fills and s_ready drops.
`default_nettype none

module code39_bar_module_packer (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [7:0]                           s_char_code,
    input  wire                                  s_end_of_message,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [7:0]                           m_pattern_byte,
    output logic                                 m_last_of_run,
    output logic                                 m_bad_char,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  c39p_pkg::cfg_index_t           cfg_index,
    input  wire  [c39p_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import c39p_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    entry_t  push_entry, pop_entry;
    logic    push_valid, push_ready;
    logic    pop_valid, pop_ready;

    // config writes land at once; the port never stalls
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_WIDE:   cfg_next.wide   = cfg_data[WIDE_W-1:0];
                CFG_NARROW: cfg_next.narrow = cfg_data[NARROW_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wide   <= WIDE_RESET;
            cfg_reg.narrow <= NARROW_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: lookup and expansion of the character into its module string
    c39p_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_end_of_message (s_end_of_message),
        .cfg              (cfg_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_entry       (push_entry)
    );

    // decoupling queue
    c39p_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // back: carry merge and byte emission, owns the output register
    c39p_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_entry      (pop_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pattern_byte (m_pattern_byte),
        .m_last_of_run  (m_last_of_run),
        .m_bad_char     (m_bad_char)
    );

endmodule

`default_nettype wire

FILE: tb/code39_bar_module_packer_test.sv
// Self-checking testbench for the Code 39 bar module packer.
`timescale 1ns / 100ps

module code39_bar_module_packer_test;
    import c39p_pkg::*;

    // One character transaction on the input channel.
    typedef struct packed {
        logic [7:0] code;
        logic       eom;
    } char_txn_t;

    // One byte transaction on the result channel.
    typedef struct packed {
        logic [7:0] pattern;
        logic       last;
        logic       bad;
    } bar_byte_t;

    localparam int SYMBOLS     = 44;
    localparam int IDLE_LIMIT  = 3000;  // cycles with no transaction on any channel
    localparam int SETTLE      = 16;    // back-end drain time before a register write
    localparam int LONG_HOLD   = 60;    // receiver hold-off that backs up the input queue
    localparam int RAND_PHASE  = 16;

    // Symbol characters, first symbol in the top byte.
    localparam logic [8*SYMBOLS-1:0] SYMBOL_CHARS =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. *$/+%";

    // Wide/narrow map of the nine elements, first symbol in the top 9 bits.
    // Within a symbol the msb is the first element (a bar); 1 = wide.
    localparam logic [9*SYMBOLS-1:0] SYMBOL_WIDE = {
        9'b000110100, 9'b100100001, 9'b001100001, 9'b101100000, 9'b000110001,
        9'b100110000, 9'b001110000, 9'b000100101, 9'b100100100, 9'b001100100,
        9'b100001001, 9'b001001001, 9'b101001000, 9'b000011001, 9'b100011000,
        9'b001011000, 9'b000001101, 9'b100001100, 9'b001001100, 9'b000011100,
        9'b100000011, 9'b001000011, 9'b101000010, 9'b000010011, 9'b100010010,
        9'b001010010, 9'b000000111, 9'b100000110, 9'b001000110, 9'b000010110,
        9'b110000001, 9'b011000001, 9'b111000000, 9'b010010001, 9'b110010000,
        9'b011010000, 9'b010000101, 9'b110000100, 9'b011000100, 9'b010010100,
        9'b010101000, 9'b010100010, 9'b010001010, 9'b000101010
    };

    // DUT connections; every input starts at a known value.
    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_char_code      = 8'h00;
    logic                  s_end_of_message = 1'b0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [7:0]            m_pattern_byte;
    logic                  m_last_of_run;
    logic                  m_bad_char;
    logic                  cfg_valid        = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index        = CFG_WIDE;
    logic [CFG_DATA_W-1:0] cfg_data         = '0;

    // Predictor state: register copies and the module carry.
    logic [WIDE_W-1:0]   wide_cfg    = WIDE_RESET;
    logic [NARROW_W-1:0] narrow_cfg  = NARROW_RESET;
    logic [6:0]          carry_bits  = '0;
    logic [2:0]          carry_count = '0;

    char_txn_t char_fifo[$];      // characters waiting for the driver
    bar_byte_t byte_expect_q[$];  // predicted bytes, oldest first

    // Stimulus control shared between the sequence and the two channel processes.
    logic     no_idle   = 1'b0;  // last part of the run: no idling on either side
    logic     hold_req  = 1'b0;  // asks the receiver for one long hold-off
    int       send_gap  = 0;
    int       stall_cnt = 0;
    int       hold_cnt  = 0;
    int       idle_cycles = 0;

    // Bookkeeping for the summary.
    int       errors        = 0;
    int       chars_sent    = 0;
    int       bytes_checked = 0;
    int       bad_seen      = 0;
    int       reg_writes    = 0;

    char_txn_t next_char;
    bar_byte_t got;
    bar_byte_t want;

    code39_bar_module_packer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pattern_byte   (m_pattern_byte),
        .m_last_of_run    (m_last_of_run),
        .m_bad_char       (m_bad_char),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Expands one accepted character into its bar/space modules, packs them
    // lsb first after the carry, and queues every byte that it completes.
    task automatic encode_char(input logic [7:0] code, input logic eom);
        logic [63:0] acc;
        logic [8:0]  mask;
        logic        hit;
        logic        flush;
        bar_byte_t   res;
        int unsigned wide, narrow, width, nbits, nfull, cnt;
        hit  = 1'b0;
        mask = '0;
        for (int i = 0; i < SYMBOLS; i++) begin
            if (!hit && SYMBOL_CHARS[(SYMBOLS-1-i)*8 +: 8] == code) begin
                hit  = 1'b1;
                mask = SYMBOL_WIDE[(SYMBOLS-1-i)*9 +: 9];
            end
        end
        if (!hit) begin
            // Unknown character: one flagged byte, carry untouched, eom ignored.
            res.pattern = 8'h00;
            res.last    = 1'b1;
            res.bad     = 1'b1;
            byte_expect_q.push_back(res);
            return;
        end
        // Registers above range saturate; zero stays zero.
        wide   = 32'((wide_cfg > WIDE_CAP) ? WIDE_CAP : wide_cfg);
        narrow = 32'((narrow_cfg > NARROW_CAP) ? NARROW_CAP : narrow_cfg);
        acc    = {57'b0, carry_bits};
        nbits  = 32'(carry_count);
        for (int e = 0; e < ELEMENT_COUNT; e++) begin
            width = mask[ELEMENT_COUNT-1-e] ? wide : narrow;
            for (int k = 0; k < width; k++) begin
                if (e % 2 == 0)
                    acc[nbits] = 1'b1;
                nbits++;
            end
        end
        nbits += narrow;  // inter-character gap, all spaces
        nfull = nbits / 8;
        flush = eom && (nbits % 8 != 0);
        cnt   = nfull + (flush ? 1 : 0);
        for (int k = 0; k < cnt; k++) begin
            res.pattern = acc[k*8 +: 8];
            res.last    = (k == cnt - 1);
            res.bad     = 1'b0;
            byte_expect_q.push_back(res);
        end
        if (flush) begin
            carry_bits  = '0;
            carry_count = '0;
        end else begin
            carry_bits  = acc[nfull*8 +: 7];
            carry_count = 3'(nbits % 8);
        end
    endtask

    // Input driver: pulls characters from char_fifo, holds them until taken,
    // and inserts random gaps between transactions.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                encode_char(s_char_code, s_end_of_message);
                chars_sent++;
            end
            // A transaction still waiting for s_ready keeps its payload.
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (char_fifo.size() != 0 && !no_idle && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(0, 12);
                    s_valid <= 1'b0;
                end else if (char_fifo.size() != 0) begin
                    next_char = char_fifo.pop_front();
                    s_valid          <= 1'b1;
                    s_char_code      <= next_char.code;
                    s_end_of_message <= next_char.eom;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each byte against the oldest prediction and
    // drives m_ready with random stalls plus the one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.pattern = m_pattern_byte;
                got.last    = m_last_of_run;
                got.bad     = m_bad_char;
                if (byte_expect_q.size() == 0) begin
                    $display("%0t: unexpected byte: expected none, actual %02h last %0b bad %0b",
                             $time, got.pattern, got.last, got.bad);
                    errors++;
                end else begin
                    want = byte_expect_q.pop_front();
                    if (got.pattern !== want.pattern) begin
                        $display("%0t: pattern_byte mismatch: expected %02h, actual %02h",
                                 $time, want.pattern, got.pattern);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                                 $time, want.last, got.last);
                        errors++;
                    end
                    if (got.bad !== want.bad) begin
                        $display("%0t: bad_char mismatch: expected %0b, actual %0b",
                                 $time, want.bad, got.bad);
                        errors++;
                    end
                    bytes_checked++;
                    if (want.bad)
                        bad_seen++;
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                stall_cnt = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no channel has moved for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes still expected", $time, byte_expect_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_char(input logic [7:0] code, input logic eom);
        char_txn_t t;
        t.code = code;
        t.eom  = eom;
        char_fifo.push_back(t);
    endtask

    // Mostly valid symbols, some arbitrary bytes, an end of message now and then.
    task automatic queue_random(input int count);
        logic [7:0] code;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 85)
                code = SYMBOL_CHARS[(SYMBOLS-1-$urandom_range(0, SYMBOLS-1))*8 +: 8];
            else
                code = 8'($urandom_range(0, 255));
            queue_char(code, $urandom_range(0, 4) == 0);
        end
    endtask

    // Waits until every character has gone in and every byte has come out,
    // then lets the back end settle (a character may leave no byte behind).
    task automatic wait_quiet();
        do @(negedge aclk);
        while (char_fifo.size() != 0 || s_valid || byte_expect_q.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_WIDE)
            wide_cfg = data[WIDE_W-1:0];
        else
            narrow_cfg = data[NARROW_W-1:0];
        reg_writes++;
    endtask

    // Sets both registers, wide then narrow; bit 2 of a narrow write is don't-care, so randomize it.
    task automatic set_widths(input logic [2:0] wide, input logic [1:0] narrow);
        write_reg(CFG_WIDE, wide);
        write_reg(CFG_NARROW, {1'($urandom_range(0, 1)), narrow});
    endtask

    // Test sequence.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset widths (13 modules per symbol). Unknown bytes at both
        // code extremes, both with eom set to show it is ignored; flushes with
        // pending modules; ends with three plain symbols so 7 modules carry over.
        queue_char("*", 1'b0);
        queue_char("A", 1'b0);
        queue_char("0", 1'b0);
        queue_char(8'h00, 1'b1);
        queue_char("Z", 1'b0);
        queue_char(8'hFF, 1'b1);
        queue_char("%", 1'b0);
        queue_char(" ", 1'b1);
        queue_char("9", 1'b1);
        queue_char("-", 1'b0);
        queue_char(".", 1'b0);
        queue_char("$", 1'b0);
        wait_quiet();

        // Both registers above range: 32 modules per symbol on top of a 7-module
        // carry gives four bytes, and with eom the fifth (flush) byte.
        set_widths(3'd7, 2'd3);
        queue_char("W", 1'b0);
        queue_char("W", 1'b1);
        queue_char("*", 1'b0);
        queue_char("/", 1'b1);
        wait_quiet();

        // All widths zero: symbols add nothing, eom with nothing pending is silent.
        set_widths(3'd0, 2'd0);
        queue_char("A", 1'b1);
        queue_char("K", 1'b0);
        queue_char("U", 1'b0);
        queue_char(8'h7F, 1'b0);
        wait_quiet();

        // Only narrow elements count: 7 modules, so the first symbol fills no byte.
        set_widths(3'd0, 2'd1);
        queue_char("Q", 1'b0);
        queue_char("+", 1'b1);
        wait_quiet();

        // Random phases across several width settings.
        set_widths(WIDE_RESET, NARROW_RESET);
        queue_random(RAND_PHASE);
        wait_quiet();

        // Receiver holds off long enough to back the input up to s_ready low.
        set_widths(3'd6, 2'd2);
        queue_random(RAND_PHASE);
        hold_req = 1'b1;
        wait_quiet();

        // Sender pauses mid-phase until all results are in.
        set_widths(3'd3, 2'd1);
        queue_random(RAND_PHASE / 2);
        wait_quiet();
        queue_random(RAND_PHASE / 2);
        wait_quiet();

        set_widths(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
        queue_random(RAND_PHASE);
        wait_quiet();

        set_widths(3'd5, 2'd2);
        queue_random(RAND_PHASE);
        wait_quiet();

        // Final stretch at full rate on both sides.
        no_idle = 1'b1;
        set_widths(3'd4, 2'd1);
        queue_random(RAND_PHASE);
        wait_quiet();

        if (byte_expect_q.size() != 0) begin
            $display("%0t: %0d expected bytes never arrived", $time, byte_expect_q.size());
            errors++;
        end
        $display("Covered %0d characters over %0d register writes: %0d bytes checked, %0d flagged",
                 chars_sent, reg_writes, bytes_checked, bad_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: code39_bar_module_packer.f
design/c39p_pkg.sv
design/c39p_front.sv
design/c39p_queue.sv
design/c39p_back.sv
design/code39_bar_module_packer.sv
tb/code39_bar_module_packer_test.sv
